### hdl/c2d_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the streaming 3x3 valid-mode convolution.
// No dependencies.
package c2d_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int CONV_W     = 35;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;
    localparam int IMG_W_W    = 11;
    localparam int IMG_H_W    = 12;

    typedef logic signed [SAMPLE_W-1:0]   t_sample;
    typedef logic signed [CONV_W-1:0]     t_conv;
    typedef logic [CFG_IDX_W-1:0]         t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]        t_cfg_data;
    typedef logic [CFG_DATA_W-1:0]        t_kernel_row;

    // register indexes of the configuration port
    localparam t_cfg_index CFG_KERNEL_TOP    = 3'd0;
    localparam t_cfg_index CFG_KERNEL_MIDDLE = 3'd1;
    localparam t_cfg_index CFG_KERNEL_BOTTOM = 3'd2;
    localparam t_cfg_index CFG_IMAGE_WIDTH   = 3'd3;
    localparam t_cfg_index CFG_IMAGE_HEIGHT  = 3'd4;

    localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RESET  = 11'd28;
    localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RESET = 12'd28;

endpackage

### hdl/conv2d_valid_3x3_stream.sv
`timescale 1ns / 1ps
// Streaming valid-mode 3x3 cross-correlation: line stores, window, MAC tree.
// Depends on c2d_pkg.
//
// One sample is accepted every clock cycle while o_stall is low. A sample goes
// through five register stages (line store read, window shift and write back,
// nine products, three partial sums, output register). Each line store is one
// synchronous memory with one read and one write per cycle: the column address
// is read when the sample is accepted and the same entry is written back from
// the stage-1 registers; consecutive samples within a frame hit different
// columns, so no forwarding is needed. Output back
// pressure is absorbed by a one-entry skid register; o_stall rises only while it
// is full. Results come only for pixels at row and column two or later;
// frame_last marks the result of the last pixel of a frame. Writing the width
// or height restarts the frame at row 0, column 0.
module conv2d_valid_3x3_stream #(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  c2d_pkg::t_sample      i_sample,
    output logic                  o_valid,
    input  logic                  i_stall,
    output c2d_pkg::t_conv        o_conv_value,
    output logic                  o_frame_last,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  c2d_pkg::t_cfg_index   i_cfg_index,
    input  c2d_pkg::t_cfg_data    i_cfg_data
);
    import c2d_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);
    localparam logic [12:0] MAX_W13 = 13'(MAX_WIDTH);

    // configuration
    t_kernel_row            r_kernel [3];
    logic [IMG_W_W-1:0]     r_image_width;
    logic [IMG_H_W-1:0]     r_image_height;
    logic [12:0]            w_use;
    logic [12:0]            h_use;

    // frame position
    logic [AW-1:0]          r_col, n_col;
    logic [IMG_H_W-1:0]     r_row, n_row;
    logic                   last_col, last_row;

    // line stores
    logic [SAMPLE_W-1:0]    mem_upper [MAX_WIDTH];
    logic [SAMPLE_W-1:0]    mem_lower [MAX_WIDTH];
    logic [SAMPLE_W-1:0]    r_rd_upper, r_rd_lower;

    // pipeline
    logic                   en, accept;
    logic                   r_s1_valid, r_s1_emit, r_s1_last;
    logic [AW-1:0]          r_s1_col;
    t_sample                r_s1_sample;
    t_sample                r_win [9];
    logic                   r_s2_valid, r_s2_emit, r_s2_last;
    t_sample                w_coef [9];
    logic signed [31:0]     r_prod [9];
    logic                   r_s3_valid, r_s3_last;
    logic signed [33:0]     r_part [3];
    logic                   r_s4_valid, r_s4_last;
    t_conv                  sum;

    // output register and skid
    logic                   r_out_valid, n_out_valid;
    t_conv                  r_out_value;
    logic                   r_out_last;
    logic                   r_skid_valid, n_skid_valid;
    t_conv                  r_skid_value;
    logic                   r_skid_last;
    logic                   out_take, push;

    assign en          = !r_skid_valid;
    assign o_stall     = r_skid_valid;
    assign accept      = i_valid && en;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_image_width < 11'd3) begin
            w_use = 13'd3;
        end else if (13'(r_image_width) > MAX_W13) begin
            w_use = MAX_W13;
        end else begin
            w_use = 13'(r_image_width);
        end
        h_use = (r_image_height < 12'd3) ? 13'd3 : 13'(r_image_height);
    end

    assign last_col = (13'(r_col) + 13'd1) >= w_use;
    assign last_row = (13'(r_row) + 13'd1) >= h_use;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (accept) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + 1'b1;
            end else begin
                n_col = r_col + 1'b1;
            end
        end
        if (i_cfg_valid && (i_cfg_index == CFG_IMAGE_WIDTH ||
                            i_cfg_index == CFG_IMAGE_HEIGHT)) begin
            n_col = '0;
            n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel[0]    <= '0;
            r_kernel[1]    <= '0;
            r_kernel[2]    <= '0;
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
            r_col          <= '0;
            r_row          <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_KERNEL_TOP:    r_kernel[0]    <= i_cfg_data;
                    CFG_KERNEL_MIDDLE: r_kernel[1]    <= i_cfg_data;
                    CFG_KERNEL_BOTTOM: r_kernel[2]    <= i_cfg_data;
                    CFG_IMAGE_WIDTH:   r_image_width  <= i_cfg_data[IMG_W_W-1:0];
                    CFG_IMAGE_HEIGHT:  r_image_height <= i_cfg_data[IMG_H_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // read the column on accept, write it back one stage later
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rd_upper <= mem_upper[r_col];
            r_rd_lower <= mem_lower[r_col];
            if (r_s1_valid) begin
                mem_upper[r_s1_col] <= r_rd_lower;
                mem_lower[r_s1_col] <= r_s1_sample;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_col    <= r_col;
            r_s1_sample <= i_sample;
            r_s1_emit   <= (r_row >= 12'd2) && (13'(r_col) >= 13'd2);
            r_s1_last   <= last_col && last_row;
        end
    end

    // shift the window; top row is the oldest line, column 0 the oldest pixel
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (en && r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]   <= r_win[r*3+1];
                r_win[r*3+1] <= r_win[r*3+2];
            end
            r_win[2] <= r_rd_upper;
            r_win[5] <= r_rd_lower;
            r_win[8] <= r_s1_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_emit <= r_s1_emit;
            r_s2_last <= r_s1_last;
        end
    end

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_coef[r*3+k] = r_kernel[r][16*k +: 16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                r_prod[i] <= w_coef[i] * r_win[i];
            end
            r_s3_last <= r_s2_last;
            for (int j = 0; j < 3; j++) begin
                r_part[j] <= 34'(r_prod[3*j]) + 34'(r_prod[3*j+1]) + 34'(r_prod[3*j+2]);
            end
            r_s4_last <= r_s3_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
        end else if (en) begin
            r_s1_valid <= accept;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid && r_s2_emit;
            r_s4_valid <= r_s3_valid;
        end
    end

    assign sum      = 35'(r_part[0]) + 35'(r_part[1]) + 35'(r_part[2]);
    assign out_take = r_out_valid && !i_stall;
    assign push     = en && r_s4_valid;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (r_out_valid && !out_take) begin
                n_skid_valid = 1'b1;
            end else begin
                n_out_valid = 1'b1;
            end
        end else if (out_take) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_value <= r_skid_value;
                r_out_last  <= r_skid_last;
            end
        end else if (push) begin
            if (r_out_valid && !out_take) begin
                r_skid_value <= sum;
                r_skid_last  <= r_s4_last;
            end else begin
                r_out_value <= sum;
                r_out_last  <= r_s4_last;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_conv_value = r_out_value;
    assign o_frame_last = r_out_last;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid holds a result while the output register is empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_valid) |-> $past(r_out_valid && i_stall))
        else $error("skid filled without an output stall");

    a_accept_enters_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_s1_valid)
        else $error("accepted request did not enter the pipeline");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        13'(r_col) < w_use)
        else $error("column counter beyond the row width");

endmodule
